// ===== rtl/mspc_pkg.sv =====
// Shared types and constants for the motor speed PID controller.
package mspc_pkg;

    localparam int PERIOD_W  = 16;
    localparam int MAXP_W    = 17;
    localparam int DIVIDE_W  = 8;
    localparam int SCALE_W   = 20;
    localparam int GAIN_W    = 16;
    localparam int TARGET_W  = 8;
    localparam int SPEED_W   = 16;
    localparam int DUTY_W    = 8;
    localparam int ERR_W     = 18;
    localparam int DERIV_W   = 19;
    localparam int ESUM_W    = 32;
    localparam int PROD_W    = GAIN_W + ESUM_W;
    localparam int ACC_W     = PROD_W + 2;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 20;
    localparam int STEP_W    = $clog2(SCALE_W);

    localparam logic [PERIOD_W-1:0]   MIN_PERIOD_RST  = 16'd400;
    localparam logic [MAXP_W-1:0]     MAX_PERIOD_RST  = 17'd120000;
    localparam logic [DIVIDE_W-1:0]   TICK_DIVIDE_RST = 8'd10;
    localparam logic [SCALE_W-1:0]    SPEED_SCALE_RST = 20'd625000;
    localparam logic signed [GAIN_W-1:0] GAIN_RST     = 16'sd1;

    localparam logic [ESUM_W-1:0] ESUM_MAX = 32'h7FFF_FFFF;
    localparam logic [ESUM_W-1:0] ESUM_MIN = 32'h8000_0000;
    localparam logic [SPEED_W-1:0] SPEED_MAX = 16'hFFFF;
    localparam logic [DUTY_W-1:0]  DUTY_MAX  = 8'hFF;

    typedef enum logic [1:0] {
        REQ_EDGE   = 2'd0,
        REQ_TICK   = 2'd1,
        REQ_TARGET = 2'd2
    } t_req;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MIN_PERIOD  = 3'd0,
        CFG_MAX_PERIOD  = 3'd1,
        CFG_TICK_DIVIDE = 3'd2,
        CFG_SPEED_SCALE = 3'd3,
        CFG_GAIN_P      = 3'd4,
        CFG_GAIN_I      = 3'd5,
        CFG_GAIN_D      = 3'd6
    } t_cfg_idx;

    typedef enum logic [1:0] {
        MUL_P = 2'd0,
        MUL_I = 2'd1,
        MUL_D = 2'd2
    } t_mul_sel;

    typedef struct packed {
        logic [PERIOD_W-1:0]        min_period;
        logic [MAXP_W-1:0]          max_period;
        logic [DIVIDE_W-1:0]        tick_divide;
        logic [SCALE_W-1:0]         speed_scale;
        logic signed [GAIN_W-1:0]   gain_p;
        logic signed [GAIN_W-1:0]   gain_i;
        logic signed [GAIN_W-1:0]   gain_d;
    } t_cfg;

    typedef struct packed {
        logic     per_load;
        logic     win_upd;
        logic     sp_load;
        logic     tick_adv;
        logic     tick_clr;
        logic     div_start;
        logic     div_step;
        logic     spd_cap;
        logic     err_cap;
        logic     esum_cap;
        logic     mul_en;
        t_mul_sel mul_sel;
        logic     acc_load;
        logic     acc_add;
        logic     out_load;
    } t_cmd;

    typedef struct packed {
        logic period_ok;
        logic tick_hit;
        logic out_free;
    } t_sts;

endpackage

// ===== rtl/mspc_ctrl.sv =====
// Sequencer for the speed controller: decodes items and steps the update.
module mspc_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  logic [1:0]           i_req_type,
    input  mspc_pkg::t_sts       i_sts,
    output logic                 o_ready,
    output mspc_pkg::t_cmd       o_cmd
);

    typedef enum logic [10:0] {
        ST_IDLE = 11'b000_0000_0001,
        ST_WIN  = 11'b000_0000_0010,
        ST_DIV  = 11'b000_0000_0100,
        ST_SPD  = 11'b000_0000_1000,
        ST_ERR  = 11'b000_0001_0000,
        ST_ESUM = 11'b000_0010_0000,
        ST_MULP = 11'b000_0100_0000,
        ST_MULI = 11'b000_1000_0000,
        ST_MULD = 11'b001_0000_0000,
        ST_ACC  = 11'b010_0000_0000,
        ST_OUT  = 11'b100_0000_0000
    } t_state;

    t_state                          r_state, n_state;
    logic [mspc_pkg::STEP_W-1:0]     r_step, n_step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end

    assign o_ready = (r_state == ST_IDLE);

    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        o_cmd   = '0;
        o_cmd.mul_sel = mspc_pkg::MUL_P;
        unique case (r_state)
            ST_IDLE: begin
                n_step = '0;
                if (i_valid) begin
                    unique case (i_req_type)
                        mspc_pkg::REQ_EDGE: begin
                            if (i_sts.period_ok) begin
                                o_cmd.per_load = 1'b1;
                                n_state = ST_WIN;
                            end
                        end
                        mspc_pkg::REQ_TICK: begin
                            if (i_sts.tick_hit) begin
                                o_cmd.tick_clr  = 1'b1;
                                o_cmd.div_start = 1'b1;
                                n_state = ST_DIV;
                            end else begin
                                o_cmd.tick_adv = 1'b1;
                            end
                        end
                        mspc_pkg::REQ_TARGET: o_cmd.sp_load = 1'b1;
                        default: ;
                    endcase
                end
            end
            ST_WIN: begin
                o_cmd.win_upd = 1'b1;
                n_state = ST_IDLE;
            end
            ST_DIV: begin
                o_cmd.div_step = 1'b1;
                n_step = r_step + 1'b1;
                if (r_step == mspc_pkg::STEP_W'(mspc_pkg::SCALE_W - 1)) begin
                    n_state = ST_SPD;
                end
            end
            ST_SPD: begin
                o_cmd.spd_cap = 1'b1;
                n_state = ST_ERR;
            end
            ST_ERR: begin
                o_cmd.err_cap = 1'b1;
                n_state = ST_ESUM;
            end
            ST_ESUM: begin
                o_cmd.esum_cap = 1'b1;
                n_state = ST_MULP;
            end
            ST_MULP: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = mspc_pkg::MUL_P;
                n_state = ST_MULI;
            end
            ST_MULI: begin
                o_cmd.mul_en   = 1'b1;
                o_cmd.mul_sel  = mspc_pkg::MUL_I;
                o_cmd.acc_load = 1'b1;
                n_state = ST_MULD;
            end
            ST_MULD: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = mspc_pkg::MUL_D;
                o_cmd.acc_add = 1'b1;
                n_state = ST_ACC;
            end
            ST_ACC: begin
                o_cmd.acc_add = 1'b1;
                n_state = ST_OUT;
            end
            ST_OUT: begin
                // hold until the result register is free
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

endmodule

// ===== rtl/mspc_dp.sv =====
// Datapath: period window, speed divider, PID arithmetic and result register.
module mspc_dp #(
    parameter int WINDOW_LEN   = 64,
    parameter int WINDOW_SHIFT = 6
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  mspc_pkg::t_cfg                        i_cfg,
    input  mspc_pkg::t_cmd                        i_cmd,
    output mspc_pkg::t_sts                        o_sts,
    input  logic [mspc_pkg::PERIOD_W-1:0]         i_period_ticks,
    input  logic [mspc_pkg::TARGET_W-1:0]         i_target_rpm,
    input  logic                                  i_ready,
    output logic                                  o_valid,
    output logic [mspc_pkg::DUTY_W-1:0]           o_drive_duty,
    output logic [mspc_pkg::SPEED_W-1:0]          o_speed_rpm,
    output logic                                  o_drive_clamped
);

    localparam int HEAD_W = $clog2(WINDOW_LEN);
    localparam int SUM_W  = mspc_pkg::PERIOD_W + HEAD_W;

    // window store and running sum
    logic [mspc_pkg::PERIOD_W-1:0] r_win [WINDOW_LEN];
    logic [mspc_pkg::PERIOD_W-1:0] r_win_rd;
    logic [mspc_pkg::PERIOD_W-1:0] r_period;
    logic [HEAD_W-1:0]             r_head;
    logic                          r_wrapped;
    logic [SUM_W-1:0]              r_sum;
    logic [mspc_pkg::PERIOD_W-1:0] win_old;

    logic [mspc_pkg::DIVIDE_W-1:0] r_tick;
    logic [mspc_pkg::TARGET_W-1:0] r_sp;

    // divider
    logic [SUM_W-1:0]              mean;
    logic [SUM_W-1:0]              r_den;
    logic [SUM_W-1:0]              r_rem;
    logic [mspc_pkg::SCALE_W-1:0]  r_quo;
    logic                          r_den_zero;
    logic [SUM_W:0]                trial;
    logic                          trial_ge;

    // PID
    logic [mspc_pkg::SPEED_W-1:0]        r_speed;
    logic signed [mspc_pkg::ERR_W-1:0]   r_err;
    logic signed [mspc_pkg::ERR_W-1:0]   r_last_err;
    logic signed [mspc_pkg::DERIV_W-1:0] r_deriv;
    logic signed [mspc_pkg::ESUM_W-1:0]  r_esum;
    logic [mspc_pkg::ESUM_W:0]           esum_next;
    logic signed [mspc_pkg::GAIN_W-1:0]  mul_a;
    logic signed [mspc_pkg::ESUM_W-1:0]  mul_b;
    logic signed [mspc_pkg::PROD_W-1:0]  prod_c;
    logic signed [mspc_pkg::PROD_W-1:0]  r_prod;
    logic signed [mspc_pkg::ACC_W-1:0]   r_acc;
    logic signed [mspc_pkg::ACC_W-1:0]   prod_ext;

    logic                          r_out_valid;
    logic [mspc_pkg::DUTY_W-1:0]   r_duty;
    logic [mspc_pkg::SPEED_W-1:0]  r_out_speed;
    logic                          r_clamped;

    // status
    assign o_sts.period_ok = (i_period_ticks > i_cfg.min_period) &&
                             ({1'b0, i_period_ticks} < i_cfg.max_period);
    assign o_sts.tick_hit  = (r_tick >= i_cfg.tick_divide);
    assign o_sts.out_free  = !r_out_valid || i_ready;

    // entries not yet overwritten since reset read as zero
    assign win_old = r_wrapped ? r_win_rd : '0;

    always_ff @(posedge i_clk) begin
        r_win_rd <= r_win[r_head];
        if (i_cmd.win_upd) begin
            r_win[r_head] <= r_period;
        end
        if (i_cmd.per_load) begin
            r_period <= i_period_ticks;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head    <= '0;
            r_wrapped <= 1'b0;
            r_sum     <= '0;
            r_tick    <= '0;
            r_sp      <= '0;
        end else begin
            if (i_cmd.win_upd) begin
                r_sum <= r_sum - SUM_W'(win_old) + SUM_W'(r_period);
                if (r_head == HEAD_W'(WINDOW_LEN - 1)) begin
                    r_head    <= '0;
                    r_wrapped <= 1'b1;
                end else begin
                    r_head <= r_head + 1'b1;
                end
            end
            if (i_cmd.tick_clr) begin
                r_tick <= '0;
            end else if (i_cmd.tick_adv) begin
                r_tick <= r_tick + 1'b1;
            end
            if (i_cmd.sp_load) begin
                r_sp <= i_target_rpm;
            end
        end
    end

    // restoring divide, one quotient bit a cycle
    assign mean     = r_sum >> WINDOW_SHIFT;
    assign trial    = {r_rem, r_quo[mspc_pkg::SCALE_W-1]};
    assign trial_ge = (trial >= {1'b0, r_den});

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_start) begin
            r_den      <= mean;
            r_rem      <= '0;
            r_quo      <= i_cfg.speed_scale;
            r_den_zero <= (mean == '0);
        end else if (i_cmd.div_step) begin
            r_rem <= trial_ge ? SUM_W'(trial - {1'b0, r_den}) : trial[SUM_W-1:0];
            r_quo <= {r_quo[mspc_pkg::SCALE_W-2:0], trial_ge};
        end
    end

    // saturating error sum
    assign esum_next = {r_esum[mspc_pkg::ESUM_W-1], r_esum}
                     + {{(mspc_pkg::ESUM_W - mspc_pkg::ERR_W + 1){r_err[mspc_pkg::ERR_W-1]}},
                        r_err};

    // shared multiplier
    always_comb begin
        case (i_cmd.mul_sel)
            mspc_pkg::MUL_I: begin
                mul_a = i_cfg.gain_i;
                mul_b = r_esum;
            end
            mspc_pkg::MUL_D: begin
                mul_a = i_cfg.gain_d;
                mul_b = mspc_pkg::ESUM_W'(r_deriv);
            end
            default: begin
                mul_a = i_cfg.gain_p;
                mul_b = mspc_pkg::ESUM_W'(r_err);
            end
        endcase
    end

    assign prod_c   = mul_a * mul_b;
    assign prod_ext = {{(mspc_pkg::ACC_W - mspc_pkg::PROD_W){r_prod[mspc_pkg::PROD_W-1]}},
                       r_prod};

    always_ff @(posedge i_clk) begin
        if (i_cmd.spd_cap) begin
            if (r_den_zero) begin
                r_speed <= '0;
            end else if (|r_quo[mspc_pkg::SCALE_W-1:mspc_pkg::SPEED_W]) begin
                r_speed <= mspc_pkg::SPEED_MAX;
            end else begin
                r_speed <= r_quo[mspc_pkg::SPEED_W-1:0];
            end
        end
        if (i_cmd.err_cap) begin
            r_err <= $signed({{(mspc_pkg::ERR_W - mspc_pkg::TARGET_W){1'b0}}, r_sp})
                   - $signed({{(mspc_pkg::ERR_W - mspc_pkg::SPEED_W){1'b0}}, r_speed});
        end
        if (i_cmd.mul_en) begin
            r_prod <= prod_c;
        end
        if (i_cmd.acc_load) begin
            r_acc <= prod_ext;
        end else if (i_cmd.acc_add) begin
            r_acc <= r_acc + prod_ext;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_esum     <= '0;
            r_last_err <= '0;
            r_deriv    <= '0;
        end else if (i_cmd.esum_cap) begin
            if (esum_next[mspc_pkg::ESUM_W] != esum_next[mspc_pkg::ESUM_W-1]) begin
                r_esum <= esum_next[mspc_pkg::ESUM_W] ? mspc_pkg::ESUM_MIN : mspc_pkg::ESUM_MAX;
            end else begin
                r_esum <= esum_next[mspc_pkg::ESUM_W-1:0];
            end
            r_deriv    <= mspc_pkg::DERIV_W'(r_err) - mspc_pkg::DERIV_W'(r_last_err);
            r_last_err <= r_err;
        end
    end

    // result register with clamp
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_speed <= r_speed;
            if (r_acc[mspc_pkg::ACC_W-1]) begin
                r_duty    <= '0;
                r_clamped <= 1'b1;
            end else if (|r_acc[mspc_pkg::ACC_W-2:mspc_pkg::DUTY_W]) begin
                r_duty    <= mspc_pkg::DUTY_MAX;
                r_clamped <= 1'b1;
            end else begin
                r_duty    <= r_acc[mspc_pkg::DUTY_W-1:0];
                r_clamped <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_drive_duty    = r_duty;
    assign o_speed_rpm     = r_out_speed;
    assign o_drive_clamped = r_clamped;

endmodule

// ===== rtl/motor_speed_pid_controller.sv =====
// Top level of the motor speed PID controller: config registers, sequencer, datapath.
// Edge, target and non-update tick beats are accepted while idle; an in-range edge then
//   passes through the window-update state before the next beat is taken.
// Update tick: 20-step restoring divide, then speed, error, error-sum, P/I/D multiply,
//   accumulate, output (waits for a free result register), then ready for the next beat.
// Reset (i_rst_n low, synchronous): config back to defaults, window reads as zero until
//   each entry is overwritten, sum, head, divider count, set-point and PID state cleared.
module motor_speed_pid_controller #(
    parameter int WINDOW_LEN   = 64,
    parameter int WINDOW_SHIFT = 6
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // item channel
    input  logic                                 i_valid,
    output logic                                 o_ready,
    input  logic [1:0]                           i_req_type,
    input  logic [mspc_pkg::PERIOD_W-1:0]        i_period_ticks,
    input  logic [mspc_pkg::TARGET_W-1:0]        i_target_rpm,
    // result channel
    output logic                                 o_valid,
    input  logic                                 i_ready,
    output logic [mspc_pkg::DUTY_W-1:0]          o_drive_duty,
    output logic [mspc_pkg::SPEED_W-1:0]         o_speed_rpm,
    output logic                                 o_drive_clamped,
    // configuration write channel
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [mspc_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [mspc_pkg::CFG_DATA_W-1:0]      i_cfg_data
);

    mspc_pkg::t_cfg r_cfg;
    mspc_pkg::t_cmd cmd;
    mspc_pkg::t_sts sts;

    // Configuration writes are always taken; an unknown index is dropped.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.min_period  <= mspc_pkg::MIN_PERIOD_RST;
            r_cfg.max_period  <= mspc_pkg::MAX_PERIOD_RST;
            r_cfg.tick_divide <= mspc_pkg::TICK_DIVIDE_RST;
            r_cfg.speed_scale <= mspc_pkg::SPEED_SCALE_RST;
            r_cfg.gain_p      <= mspc_pkg::GAIN_RST;
            r_cfg.gain_i      <= mspc_pkg::GAIN_RST;
            r_cfg.gain_d      <= mspc_pkg::GAIN_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                mspc_pkg::CFG_MIN_PERIOD:
                    r_cfg.min_period  <= i_cfg_data[mspc_pkg::PERIOD_W-1:0];
                mspc_pkg::CFG_MAX_PERIOD:
                    r_cfg.max_period  <= i_cfg_data[mspc_pkg::MAXP_W-1:0];
                mspc_pkg::CFG_TICK_DIVIDE:
                    r_cfg.tick_divide <= i_cfg_data[mspc_pkg::DIVIDE_W-1:0];
                mspc_pkg::CFG_SPEED_SCALE:
                    r_cfg.speed_scale <= i_cfg_data[mspc_pkg::SCALE_W-1:0];
                mspc_pkg::CFG_GAIN_P:
                    r_cfg.gain_p      <= i_cfg_data[mspc_pkg::GAIN_W-1:0];
                mspc_pkg::CFG_GAIN_I:
                    r_cfg.gain_i      <= i_cfg_data[mspc_pkg::GAIN_W-1:0];
                mspc_pkg::CFG_GAIN_D:
                    r_cfg.gain_d      <= i_cfg_data[mspc_pkg::GAIN_W-1:0];
                default: ;
            endcase
        end
    end

    // Sequencer: decodes each beat and steps the divide and PID phases.
    mspc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .i_req_type (i_req_type),
        .i_sts      (sts),
        .o_ready    (o_ready),
        .o_cmd      (cmd)
    );

    // Datapath: window store, divider, shared multiplier and result register.
    mspc_dp #(
        .WINDOW_LEN   (WINDOW_LEN),
        .WINDOW_SHIFT (WINDOW_SHIFT)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg           (r_cfg),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .i_period_ticks  (i_period_ticks),
        .i_target_rpm    (i_target_rpm),
        .i_ready         (i_ready),
        .o_valid         (o_valid),
        .o_drive_duty    (o_drive_duty),
        .o_speed_rpm     (o_speed_rpm),
        .o_drive_clamped (o_drive_clamped)
    );

    // An update tick must take the block busy on the next cycle.
    a_tick_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready && i_req_type == mspc_pkg::REQ_TICK && sts.tick_hit)
        |=> !o_ready)
        else $error("update tick did not start the update sequence");

    // An edge beat stalls the input for exactly the window update when in range.
    a_edge_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready && i_req_type == mspc_pkg::REQ_EDGE)
        |=> (o_ready != $past(sts.period_ok)))
        else $error("edge beat handling disagrees with the range check");

    // A clamped drive sits at one of the two rails.
    a_clamp_rail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_drive_clamped)
        |-> (o_drive_duty == '0 || o_drive_duty == mspc_pkg::DUTY_MAX))
        else $error("clamped drive not at a rail");

endmodule
